>>> hw/rtl/lcs_pkg.sv
package lcs_pkg;

	// field widths of one word on each channel
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 31;
	localparam int TIME_W     = 32;
	localparam int CMD_W      = 3;
	localparam int TMO_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SELECT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOGIN      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_HEARTBEAT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 1'b1;

	// register reset values
	localparam logic [IDX_W-1:0] SERVER_COUNT_RST = 5'd16;
	localparam logic [TMO_W-1:0] TIMEOUT_RST      = 16'd30;

	// count value that marks a server offline
	localparam logic [CNT_W-1:0] OFFLINE_MARK = {CNT_W{1'b1}};

	// what the back end has to do with a word
	typedef enum logic [1:0] {
		KIND_SELECT,
		KIND_UPDATE,
		KIND_ECHO,
		KIND_NULL
	} lcs_kind_t;

	// classified word passed from the front end to the back end
	typedef struct packed {
		lcs_kind_t          kind;
		logic [CMD_W-1:0]   cmd;
		logic [IDX_W-1:0]   idx;
		logic [IDX_W-1:0]   last_idx;
		logic [TIME_W-1:0]  now;
	} lcs_item_t;

	// result word
	typedef struct packed {
		logic [IDX_W-1:0]  chosen;
		logic [CNT_W-1:0]  conns;
		logic              online;
		logic [TIME_W-1:0] seen;
	} lcs_result_t;

endpackage

>>> hw/rtl/lcs_front.sv
module lcs_front import lcs_pkg::*; #(
	parameter int MAX_SERVERS = 16
) (
	input  logic              push,
	output logic              full,
	input  logic [CMD_W-1:0]  command,
	input  logic [IDX_W-1:0]  server_index,
	input  logic [TIME_W-1:0] now_secs,
	input  logic [IDX_W-1:0]  server_count,
	output logic              q_push,
	output lcs_item_t         q_item,
	input  logic              q_full
);

	localparam int CAP = (MAX_SERVERS > 31) ? 31 : MAX_SERVERS;

	logic [IDX_W-1:0] n_eff;
	logic             idx_ok;

	// cap the server count at the number of table entries
	always_comb begin
		if (server_count > IDX_W'(CAP)) begin
			n_eff = IDX_W'(CAP);
		end else begin
			n_eff = server_count;
		end
	end

	assign idx_ok = (server_index != '0) && (server_index <= n_eff);

	// classify the word
	always_comb begin
		q_item.cmd      = command;
		q_item.idx      = server_index;
		q_item.now      = now_secs;
		q_item.last_idx = (n_eff == '0) ? IDX_W'(1) : n_eff;
		priority if (command == CMD_SELECT) begin
			q_item.kind = KIND_SELECT;
		end else if (command > CMD_STATUS) begin
			q_item.kind = KIND_NULL;
		end else if (!idx_ok) begin
			q_item.kind = KIND_ECHO;
		end else begin
			q_item.kind = KIND_UPDATE;
		end
	end

	assign q_push = push && !q_full;
	assign full   = q_full;

endmodule

>>> hw/rtl/lcs_queue.sv
module lcs_queue import lcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lcs_item_t item_in,
	output logic      full,
	input  logic      pop,
	output lcs_item_t item_out,
	output logic      empty
);

	lcs_item_t  slots_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign item_out = slots_q[rd_q];

	// store incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= item_in;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/lcs_back.sv
module lcs_back import lcs_pkg::*; #(
	parameter int MAX_SERVERS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [TMO_W-1:0] timeout_secs,
	input  lcs_item_t        q_item,
	input  logic             q_empty,
	output logic             q_pop,
	output lcs_result_t      result,
	output logic             result_valid,
	input  logic             result_pop
);

	localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	// server tables and their written marks
	logic [CNT_W-1:0]  cnt_mem  [MAX_SERVERS];
	logic [TIME_W-1:0] beat_mem [MAX_SERVERS];
	logic              cnt_vld_q  [MAX_SERVERS];
	logic              beat_vld_q [MAX_SERVERS];

	logic [CNT_W-1:0]  cnt_rd_q;
	logic [TIME_W-1:0] beat_rd_q;
	logic              cnt_rv_q;
	logic              beat_rv_q;

	state_t            state_q;
	lcs_item_t         item_q;
	logic [IDX_W-1:0]  scan_q;
	logic [IDX_W-1:0]  pick_q;
	logic [CNT_W-1:0]  best_cnt_q;
	logic [TIME_W-1:0] best_beat_q;
	lcs_result_t       result_q;
	logic              out_valid_q;

	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              wr_en;
	logic [CNT_W-1:0]  cur_cnt;
	logic [TIME_W-1:0] cur_beat;
	logic              take;
	logic [CNT_W-1:0]  new_cnt;
	logic [TIME_W-1:0] new_beat;
	logic              new_online;
	logic              stale;
	logic [TIME_W-1:0] age;

	// entries never written read as zero
	assign cur_cnt  = cnt_rv_q ? cnt_rd_q : '0;
	assign cur_beat = beat_rv_q ? beat_rd_q : '0;

	assign q_pop   = (state_q == ST_IDLE) && !q_empty && !out_valid_q;
	assign wr_en   = (state_q == ST_EXEC);
	assign wr_addr = AW'(item_q.idx - IDX_W'(1));

	// pick the read address
	always_comb begin
		if (state_q == ST_SCAN) begin
			rd_addr = AW'(scan_q);
		end else if (q_item.kind == KIND_SELECT) begin
			rd_addr = '0;
		end else begin
			rd_addr = AW'(q_item.idx - IDX_W'(1));
		end
	end

	// scan step: ties go to the higher index
	assign take = (scan_q == IDX_W'(1)) || (cur_cnt <= best_cnt_q);

	// apply the addressed command
	assign age   = item_q.now - cur_beat;
	assign stale = (cur_beat != '0) && (item_q.now > cur_beat)
		&& (age > TIME_W'(timeout_secs));

	always_comb begin
		new_cnt    = cur_cnt;
		new_beat   = cur_beat;
		new_online = 1'b0;
		unique case (item_q.cmd)
			CMD_LOGIN: begin
				if (cur_cnt != OFFLINE_MARK) begin
					new_cnt = cur_cnt + CNT_W'(1);
				end
			end
			CMD_DISCONNECT: begin
				if (cur_cnt != '0) begin
					new_cnt = cur_cnt - CNT_W'(1);
				end
			end
			CMD_HEARTBEAT: begin
				new_beat = item_q.now;
			end
			CMD_STATUS: begin
				if (stale) begin
					new_cnt = OFFLINE_MARK;
				end else begin
					new_online = 1'b1;
					if (cur_cnt == OFFLINE_MARK) begin
						new_cnt = '0;
					end
				end
			end
			default: begin
				new_cnt = cur_cnt;
			end
		endcase
	end

	// table storage with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_addr]  <= new_cnt;
			beat_mem[wr_addr] <= new_beat;
		end
		cnt_rd_q  <= cnt_mem[rd_addr];
		beat_rd_q <= beat_mem[rd_addr];
	end

	// written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SERVERS; i++) begin
				cnt_vld_q[i]  <= 1'b0;
				beat_vld_q[i] <= 1'b0;
			end
			cnt_rv_q  <= 1'b0;
			beat_rv_q <= 1'b0;
		end else begin
			if (wr_en) begin
				cnt_vld_q[wr_addr]  <= 1'b1;
				beat_vld_q[wr_addr] <= 1'b1;
			end
			cnt_rv_q  <= cnt_vld_q[rd_addr];
			beat_rv_q <= beat_vld_q[rd_addr];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			scan_q      <= '0;
			pick_q      <= '0;
			best_cnt_q  <= '0;
			best_beat_q <= '0;
			result_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						item_q <= q_item;
						unique case (q_item.kind)
							KIND_SELECT: begin
								scan_q  <= IDX_W'(1);
								state_q <= ST_SCAN;
							end
							KIND_UPDATE: begin
								state_q <= ST_EXEC;
							end
							KIND_ECHO: begin
								result_q        <= '0;
								result_q.chosen <= q_item.idx;
								out_valid_q     <= 1'b1;
							end
							default: begin
								result_q    <= '0;
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (take) begin
						best_cnt_q  <= cur_cnt;
						best_beat_q <= cur_beat;
						pick_q      <= scan_q;
					end
					if (scan_q == item_q.last_idx) begin
						result_q.chosen <= take ? scan_q : pick_q;
						result_q.conns  <= take ? cur_cnt : best_cnt_q;
						result_q.online <= 1'b0;
						result_q.seen   <= take ? cur_beat : best_beat_q;
						out_valid_q     <= 1'b1;
						state_q         <= ST_IDLE;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_EXEC: begin
					result_q.chosen <= item_q.idx;
					result_q.conns  <= new_cnt;
					result_q.online <= new_online;
					result_q.seen   <= new_beat;
					out_valid_q     <= 1'b1;
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result       = result_q;
	assign result_valid = out_valid_q;

endmodule

>>> hw/rtl/least_connections_selector_top.sv
// Least-connections selector.
// Commands enter as words on a queue-style input (push, full) and results
// leave on a queue-style output (empty, pop); each accepted word gives one
// result word, in order. Configuration (server count, heartbeat timeout) is
// written through wr_en / wr_index / wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Select scans the connection table one server per cycle; login,
// disconnect, heartbeat and status read the table, then write back; unknown
// commands and bad indexes give their result straight from the idle state.
// The table memory has a single read port. The back end takes the next word
// only once the result slot is free, so it does not start a new word while
// a result waits.
// A two-word queue decouples classification from execution, so input words
// are still taken while a result waits; when the receiver stalls, the back
// end holds and the queue fills until full rises.
// Reset clears every connection count and heartbeat time to zero (never
// seen), and sets server_count to 16 and timeout_secs to 30.
module least_connections_selector_top import lcs_pkg::*; #(
	parameter int MAX_SERVERS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [CMD_W-1:0]      command,
	input  logic [IDX_W-1:0]      server_index,
	input  logic [TIME_W-1:0]     now_secs,
	output logic                  empty,
	input  logic                  pop,
	output logic [IDX_W-1:0]      chosen_server,
	output logic [CNT_W-1:0]      connections,
	output logic                  online,
	output logic [TIME_W-1:0]     last_seen,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [IDX_W-1:0] server_count_q;
	logic [TMO_W-1:0] timeout_q;

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	lcs_item_t   q_in;
	lcs_item_t   q_out;
	lcs_result_t result;
	logic        result_valid;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= SERVER_COUNT_RST;
			timeout_q      <= TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SERVER_COUNT: server_count_q <= wr_data[IDX_W-1:0];
				CFG_TIMEOUT:      timeout_q      <= wr_data[TMO_W-1:0];
				default:          timeout_q      <= timeout_q;
			endcase
		end
	end

	lcs_front #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_front (
		.push         (push),
		.full         (full),
		.command      (command),
		.server_index (server_index),
		.now_secs     (now_secs),
		.server_count (server_count_q),
		.q_push       (q_push),
		.q_item       (q_in),
		.q_full       (q_full)
	);

	lcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.item_out (q_out),
		.empty    (q_empty)
	);

	lcs_back #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.timeout_secs (timeout_q),
		.q_item       (q_out),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_pop   (pop)
	);

	assign empty         = !result_valid;
	assign chosen_server = result.chosen;
	assign connections   = result.conns;
	assign online        = result.online;
	assign last_seen     = result.seen;

	// the back end starts a word only with the result slot free
	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> empty && !q_empty)
		else $error("back end took a word while a result was waiting");

	// an online server never reports the offline mark
	a_online_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && online) |-> (connections != OFFLINE_MARK))
		else $error("online result carries the offline mark");

	// an online report always names a real server
	a_online_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && online) |-> (chosen_server != '0))
		else $error("online result names server zero");

endmodule

>>> tb/sv/tb.sv
module tb;
	import lcs_pkg::*;

	localparam int N_SRV       = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYC  = 40;
	localparam int PRINT_CAP   = 60;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] now;
	} request_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  push         = 1'b0;
	logic                  full;
	logic [CMD_W-1:0]      command      = '0;
	logic [IDX_W-1:0]      server_index = '0;
	logic [TIME_W-1:0]     now_secs     = '0;
	logic                  empty;
	logic                  pop          = 1'b0;
	logic [IDX_W-1:0]      chosen_server;
	logic [CNT_W-1:0]      connections;
	logic                  online;
	logic [TIME_W-1:0]     last_seen;
	logic                  wr_en        = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index     = '0;
	logic [CFG_DATA_W-1:0] wr_data      = '0;

	// pending command words and predicted result words
	request_t    request_q[$];
	lcs_result_t answer_q[$];

	// predictor copy of the table and the registers
	logic [CNT_W-1:0]  conn_tab [1:N_SRV] = '{default: '0};
	logic [TIME_W-1:0] beat_tab [1:N_SRV] = '{default: '0};
	logic [IDX_W-1:0]  srv_count = SERVER_COUNT_RST;
	logic [TMO_W-1:0]  tmo_secs  = TIMEOUT_RST;

	int unsigned mismatch_count = 0;
	int unsigned tx_idle_pct    = 0;
	int unsigned rx_stall_pct   = 0;
	int unsigned rx_hold        = 0;
	int unsigned quiet_cycles   = 0;
	logic [TIME_W-1:0] wall     = 32'd1000;

	least_connections_selector_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.command       (command),
		.server_index  (server_index),
		.now_secs      (now_secs),
		.empty         (empty),
		.pop           (pop),
		.chosen_server (chosen_server),
		.connections   (connections),
		.online        (online),
		.last_seen     (last_seen),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned servers_in_use();
		return (srv_count > N_SRV) ? N_SRV : srv_count;
	endfunction

	// apply one command to the table copy and work out its result word
	function automatic lcs_result_t balance_step(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
			logic [TIME_W-1:0] now);
		lcs_result_t      r;
		int unsigned      n;
		int unsigned      pick;
		logic [CNT_W-1:0] best;
		logic             stale;
		r    = '0;
		n    = servers_in_use();
		pick = 1;
		best = OFFLINE_MARK;
		if (cmd == CMD_SELECT) begin
			// lowest count wins, ties go to the higher index
			for (int i = 1; i <= n; i++) begin
				if (i == 1 || conn_tab[i] <= best) begin
					best = conn_tab[i];
					pick = i;
				end
			end
			r.chosen = IDX_W'(pick);
			r.conns  = conn_tab[pick];
			r.seen   = beat_tab[pick];
			return r;
		end
		if (cmd > CMD_STATUS)
			return r;
		r.chosen = idx;
		if (idx < 1 || idx > n)
			return r;
		case (cmd)
			CMD_LOGIN: begin
				if (conn_tab[idx] != OFFLINE_MARK)
					conn_tab[idx] = conn_tab[idx] + 1'b1;
			end
			CMD_DISCONNECT: begin
				if (conn_tab[idx] != '0)
					conn_tab[idx] = conn_tab[idx] - 1'b1;
			end
			CMD_HEARTBEAT: begin
				beat_tab[idx] = now;
			end
			default: begin
				// never seen or clock behind the beat counts as fresh
				stale = beat_tab[idx] != '0 && now > beat_tab[idx] &&
					(now - beat_tab[idx]) > {16'd0, tmo_secs};
				if (stale) begin
					conn_tab[idx] = OFFLINE_MARK;
				end else begin
					r.online = 1'b1;
					if (conn_tab[idx] == OFFLINE_MARK)
						conn_tab[idx] = '0;
				end
			end
		endcase
		r.conns = conn_tab[idx];
		r.seen  = beat_tab[idx];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("tb: mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// feed the block: offer the next pending word unless idling
	always @(posedge clk) begin : p_drive
		request_t req;
		if (push && !full)
			answer_q.insert(answer_q.size(), balance_step(command, server_index, now_secs));
		if (!push || !full) begin
			if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				req = request_q.pop_front();
				push         <= 1'b1;
				command      <= req.cmd;
				server_index <= req.idx;
				now_secs     <= req.now;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// take result words and compare them with the oldest prediction
	always @(posedge clk) begin : p_watch
		lcs_result_t want;
		if (pop && !empty) begin
			if (answer_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word, chosen_server %0d", chosen_server));
			end else begin
				want = answer_q.pop_front();
				check_field("chosen_server", 64'(chosen_server), 64'(want.chosen));
				check_field("connections", 64'(connections), 64'(want.conns));
				check_field("online", 64'(online), 64'(want.online));
				check_field("last_seen", 64'(last_seen), 64'(want.seen));
			end
		end
		if (rx_hold != 0)
			rx_hold--;
		pop <= (rx_hold == 0) && ($urandom_range(99) >= rx_stall_pct);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic enqueue(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] now);
		request_t req;
		req.cmd = cmd;
		req.idx = idx;
		req.now = now;
		request_q.insert(request_q.size(), req);
	endtask

	// hold until every word is sent and every result has come back
	task automatic await_idle();
		do
			@(negedge clk);
		while (request_q.size() != 0 || push || answer_q.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= data;
		case (index)
			CFG_SERVER_COUNT: srv_count = data[IDX_W-1:0];
			default:          tmo_secs  = data[TMO_W-1:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// random words: mostly a clock moving forward, some wild times
	task automatic queue_random(int unsigned target);
		int unsigned      counted;
		int unsigned      n;
		int unsigned      r;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		logic [TIME_W-1:0] now;
		counted = 0;
		n = servers_in_use();
		while (counted < target) begin
			r = $urandom_range(99);
			if (r < 20)
				cmd = CMD_SELECT;
			else if (r < 45)
				cmd = CMD_LOGIN;
			else if (r < 60)
				cmd = CMD_DISCONNECT;
			else if (r < 75)
				cmd = CMD_HEARTBEAT;
			else if (r < 94)
				cmd = CMD_STATUS;
			else
				cmd = CMD_W'($urandom_range((1 << CMD_W) - 1, CMD_STATUS + 1));
			if (n != 0 && $urandom_range(99) < 85)
				idx = IDX_W'($urandom_range(n, 1));
			else
				idx = IDX_W'($urandom_range((1 << IDX_W) - 1));
			r = $urandom_range(99);
			if (r < 80) begin
				if ($urandom_range(3) == 0)
					wall = wall + $urandom_range(2 * tmo_secs + 2);
				else
					wall = wall + $urandom_range(2);
				now = wall;
			end else if (r < 90) begin
				now = $urandom();
			end else if (r < 92) begin
				now = '0;
			end else begin
				now = wall - $urandom_range(tmo_secs + 5);
			end
			enqueue(cmd, idx, now);
			counted++;
		end
	endtask

	task automatic run_phase(int unsigned count_cfg, int unsigned tmo_cfg, int unsigned s_pct,
			int unsigned r_pct, int unsigned n_items, bit squeeze);
		logic [CFG_DATA_W-1:0] d;
		await_idle();
		// upper bits of the count word carry junk the block must drop
		d = CFG_DATA_W'($urandom());
		d[IDX_W-1:0] = IDX_W'(count_cfg);
		write_reg(CFG_SERVER_COUNT, d);
		write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo_cfg));
		@(negedge clk);
		tx_idle_pct  = s_pct;
		rx_stall_pct = r_pct;
		if (squeeze) begin
			// stall the receiver while words keep coming, then let all drain
			rx_hold = 300;
			queue_random(n_items / 2);
			await_idle();
			queue_random(n_items - n_items / 2);
		end else begin
			queue_random(n_items);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words under the reset settings
		enqueue(CMD_SELECT, 5'd0, '0);
		enqueue(CMD_LOGIN, 5'd16, '0);
		enqueue(CMD_SELECT, 5'd0, '0);
		enqueue(CMD_LOGIN, 5'd31, '1);
		enqueue(CMD_LOGIN, 5'd0, '0);
		enqueue(CMD_DISCONNECT, 5'd1, '0);
		enqueue(CMD_HEARTBEAT, 5'd3, 32'hFFFF_FFFF);
		enqueue(CMD_STATUS, 5'd3, '0);
		enqueue(CMD_HEARTBEAT, 5'd2, 32'd100);
		enqueue(CMD_STATUS, 5'd2, 32'd130);
		enqueue(CMD_STATUS, 5'd2, 32'd131);
		// drive the offline mark down by one and log in back onto it
		enqueue(CMD_LOGIN, 5'd2, 32'd131);
		enqueue(CMD_DISCONNECT, 5'd2, 32'd131);
		enqueue(CMD_LOGIN, 5'd2, 32'd131);
		enqueue(CMD_SELECT, 5'd0, '0);
		// a zero beat reads as never seen and clears the mark
		enqueue(CMD_HEARTBEAT, 5'd2, '0);
		enqueue(CMD_STATUS, 5'd2, 32'd5000);
		enqueue(CMD_STATUS, 5'd5, 32'h8000_0000);
		for (int c = CMD_STATUS + 1; c < (1 << CMD_W); c++)
			enqueue(CMD_W'(c), 5'd31, '1);
		enqueue(CMD_HEARTBEAT, 5'd16, 32'd1);
		enqueue(CMD_DISCONNECT, 5'd16, 32'd1);
		enqueue(CMD_SELECT, 5'd0, '0);

		run_phase(16, 30, 0, 0, 350, 1'b1);
		run_phase(1, 0, 72, 0, 200, 1'b0);
		run_phase(5, 65535, 0, 72, 300, 1'b0);
		run_phase(0, 1, 12, 12, 60, 1'b0);
		run_phase(31, 7, 0, 0, 300, 1'b0);
		run_phase(16, 100, 12, 12, 400, 1'b1);
		run_phase(9, 1000, 0, 72, 300, 1'b0);

		await_idle();
		repeat (SETTLE_CYC) @(negedge clk);
		if (answer_q.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived", answer_q.size()));
		if (mismatch_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_front.sv
hw/rtl/lcs_queue.sv
hw/rtl/lcs_back.sv
hw/rtl/least_connections_selector_top.sv
tb/sv/tb.sv
